>>> hdl/dtm_pkg.sv
// ----------------------------------------------------------------------------
// Differential thrust mixer package
// Shared widths, constants, codes and sequencer states of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

    localparam int FULL_SCALE   = 10000;
    localparam int DIRECT_STEP  = 500;
    localparam int DIRECT_LIMIT = 10000;
    localparam int CMD_LIMIT    = 10000;

    localparam int DEMAND_W   = 15;
    localparam int MODE_W     = 3;
    localparam int MAX_W      = 14;
    localparam int GAIN_W     = 16;
    localparam int CMD_W      = 15;
    localparam int MAG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_SHIFT = 15;

    // magnitude of a mixed demand times the thrust limit stays below 2^X_W
    localparam int     X_W         = MAG_W + MAX_W;
    localparam int     RECIP_SHIFT = X_W;
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / FULL_SCALE;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     Q_W         = $clog2(((longint'(1) << X_W) - 1) / FULL_SCALE + 1);
    localparam int     LVL_W       = Q_W + 4;
    localparam int     MUL_A_W     = X_W;
    localparam int     MUL_B_W     = (RECIP_W > GAIN_W) ? RECIP_W : GAIN_W;
    localparam int     PROD_W      = MUL_A_W + MUL_B_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_RECIP,
        S_CHECK,
        S_FIX,
        S_OVL,
        S_OVR,
        S_CLAMP,
        S_GAIN_L,
        S_GAIN_R,
        S_GAIN_END,
        S_DONE
    } t_state;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIX    = 3'd0,
        MODE_LEFT   = 3'd1,
        MODE_RIGHT  = 3'd2,
        MODE_BOTH   = 3'd3,
        MODE_ROTATE = 3'd4,
        MODE_HOLD_A = 3'd5,
        MODE_HOLD_B = 3'd6,
        MODE_HOLD_C = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRUST_CAP = 2'd0,
        CFG_RUDDER_CAP = 2'd1,
        CFG_LEFT_GAIN  = 2'd2,
        CFG_RIGHT_GAIN = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

>>> hdl/dtm_if.sv
// ----------------------------------------------------------------------------
// Differential thrust mixer channels
// Command, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [dtm_pkg::DEMAND_W-1:0] thrust_demand;
    logic signed [dtm_pkg::DEMAND_W-1:0] rudder_demand;
    logic        [dtm_pkg::MODE_W-1:0]   mode;
    logic                                step_up;
    logic                                step_down;

    modport source (
        output valid, thrust_demand, rudder_demand, mode, step_up, step_down,
        input  ready
    );
    modport sink (
        input  valid, thrust_demand, rudder_demand, mode, step_up, step_down,
        output ready
    );
endinterface

interface dtm_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [dtm_pkg::CMD_W-1:0] left_command;
    logic signed [dtm_pkg::CMD_W-1:0] right_command;
    logic                             direct_active;

    modport source (
        output valid, left_command, right_command, direct_active,
        input  ready
    );
    modport sink (
        input  valid, left_command, right_command, direct_active,
        output ready
    );
endinterface

interface dtm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dtm_pkg::CFG_IDX_W-1:0]     index;
    logic [dtm_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/differential_thrust_mixer.sv
// ----------------------------------------------------------------------------
// Differential thrust mixer
// Turns a thrust/rudder demand or a direct step request into left and right
// motor commands in hundredths of a percent.
//
// Channels: i_cmd carries one demand item per transfer, o_res one command
// pair per item, i_cfg writes the thrust limit, rudder limit, left gain and
// right gain (indexes 0 to 3); i_cfg is always ready and must be written
// while idle only, which the block itself does not enforce.
// Mixer items (mode 0) run through one shared multiplier: scale, reciprocal
// and correction for each side, overage shift, clamp and both gains. A new
// item is taken only once the one before has left the sequencer. Direct and
// hold items skip the multiplier. The result sits in an output register;
// i_cmd is ready again as soon as the result has been handed to that
// register, so a stalled receiver holds only the next finished item, which
// then waits in the sequencer. Reset clears the configuration, the direct
// levels and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_thrust_mixer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dtm_cmd_if.sink    i_cmd,
    dtm_cfg_if.sink    i_cfg,
    dtm_res_if.source  o_res
);

    localparam int CMD_W = dtm_pkg::CMD_W;
    localparam int LVL_W = dtm_pkg::LVL_W;
    localparam int Q_W   = dtm_pkg::Q_W;
    localparam int X_W   = dtm_pkg::X_W;
    localparam int MAG_W = dtm_pkg::MAG_W;

    dtm_pkg::t_state r_state, n_state;

    logic [dtm_pkg::MAX_W-1:0]  r_thrust_cap, r_rudder_cap;
    logic [dtm_pkg::GAIN_W-1:0] r_left_gain, r_right_gain;

    logic signed [CMD_W-1:0] r_dir_l, n_dir_l, r_dir_r, n_dir_r;
    logic [MAG_W-1:0]        r_mag_l, n_mag_l, r_mag_r, n_mag_r;
    logic                    r_neg_l, n_neg_l, r_neg_r, n_neg_r;
    logic                    r_side, n_side;
    logic [dtm_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [X_W-1:0]          r_x, n_x;
    logic [Q_W-1:0]          r_q, n_q;
    logic signed [LVL_W-1:0] r_ml, n_ml, r_mr, n_mr;
    logic signed [CMD_W-1:0] r_lcmd, n_lcmd, r_rcmd, n_rcmd;
    logic                    r_direct, n_direct;
    logic                    r_out_valid, n_out_valid;
    logic signed [CMD_W-1:0] r_res_l, n_res_l, r_res_r, n_res_r;
    logic                    r_res_d, n_res_d;

    logic [dtm_pkg::MUL_A_W-1:0] mul_a;
    logic [dtm_pkg::MUL_B_W-1:0] mul_b;

    logic                    in_xfer, out_free, is_mix;
    logic signed [15:0]      mt16, mr16, thr16, rud16, thr_c, rud_c;
    logic signed [16:0]      mix_l, mix_r, abs_l, abs_r;
    logic                    up_eff, dn_eff;
    logic                    l_inc, l_dec, r_inc, r_dec;
    logic signed [CMD_W-1:0] step_l, step_r;
    logic [X_W-1:0]          fix_rem;
    logic [Q_W-1:0]          fix_q;
    logic signed [LVL_W-1:0] fix_lvl, mx_lvl, abs_ml, abs_mr;

    function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                   input logic signed [15:0] m);
        if (v > m) begin
            return m;
        end else if (v < -m) begin
            return -m;
        end
        return v;
    endfunction

    function automatic logic signed [LVL_W-1:0] clamp_lvl(input logic signed [LVL_W-1:0] v,
                                                          input logic signed [LVL_W-1:0] m);
        if (v > m) begin
            return m;
        end else if (v < -m) begin
            return -m;
        end
        return v;
    endfunction

    function automatic logic signed [CMD_W-1:0] step_level(input logic signed [CMD_W-1:0] lvl,
                                                           input logic inc,
                                                           input logic dec);
        logic signed [CMD_W:0] s;
        logic signed [CMD_W:0] st;
        logic signed [CMD_W:0] lim;
        st  = (CMD_W+1)'(dtm_pkg::DIRECT_STEP);
        lim = (CMD_W+1)'(dtm_pkg::DIRECT_LIMIT);
        s   = {lvl[CMD_W-1], lvl};
        if (inc) begin
            s = s + st;
        end else if (dec) begin
            s = s - st;
        end
        if (s > lim) begin
            s = lim;
        end else if (s < -lim) begin
            s = -lim;
        end
        return $signed(s[CMD_W-1:0]);
    endfunction

    function automatic logic signed [CMD_W-1:0] gain_cmd(
            input logic [dtm_pkg::PROD_W-1:0] p, input logic neg);
        logic [CMD_W-1:0] q;
        q = p[dtm_pkg::GAIN_SHIFT +: CMD_W];
        if (q > CMD_W'(dtm_pkg::CMD_LIMIT)) begin
            q = CMD_W'(dtm_pkg::CMD_LIMIT);
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    assign i_cmd.ready = (r_state == dtm_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign is_mix      = (dtm_pkg::t_mode'(i_cmd.mode) == dtm_pkg::MODE_MIX);

    assign o_res.valid         = r_out_valid;
    assign o_res.left_command  = r_res_l;
    assign o_res.right_command = r_res_r;
    assign o_res.direct_active = r_res_d;

    // mixer front end: clamp and mix
    assign mt16  = $signed({2'b00, r_thrust_cap});
    assign mr16  = $signed({2'b00, r_rudder_cap});
    assign thr16 = 16'(i_cmd.thrust_demand);
    assign rud16 = 16'(i_cmd.rudder_demand);
    assign thr_c = clamp16(thr16, mt16);
    assign rud_c = clamp16(rud16, mr16);
    assign mix_l = 17'(thr_c) + 17'(rud_c);
    assign mix_r = 17'(thr_c) - 17'(rud_c);
    assign abs_l = mix_l[16] ? -mix_l : mix_l;
    assign abs_r = mix_r[16] ? -mix_r : mix_r;

    // direct front end
    assign up_eff = i_cmd.step_up;
    assign dn_eff = !i_cmd.step_up && i_cmd.step_down;

    always_comb begin
        l_inc = 1'b0;
        l_dec = 1'b0;
        r_inc = 1'b0;
        r_dec = 1'b0;
        case (dtm_pkg::t_mode'(i_cmd.mode))
            dtm_pkg::MODE_LEFT: begin
                l_inc = up_eff;
                l_dec = dn_eff;
            end
            dtm_pkg::MODE_RIGHT: begin
                r_inc = up_eff;
                r_dec = dn_eff;
            end
            dtm_pkg::MODE_BOTH: begin
                l_inc = up_eff;
                l_dec = dn_eff;
                r_inc = up_eff;
                r_dec = dn_eff;
            end
            dtm_pkg::MODE_ROTATE: begin
                l_inc = up_eff;
                l_dec = dn_eff;
                r_inc = dn_eff;
                r_dec = up_eff;
            end
            default: begin
            end
        endcase
    end

    assign step_l = step_level(r_dir_l, l_inc, l_dec);
    assign step_r = step_level(r_dir_r, r_inc, r_dec);

    // reciprocal correction and overage helpers
    assign fix_rem = r_x - r_prod[X_W-1:0];
    assign fix_q   = (fix_rem >= X_W'(dtm_pkg::FULL_SCALE)) ? r_q + Q_W'(1) : r_q;
    assign fix_lvl = (r_side ? r_neg_r : r_neg_l) ? -$signed(LVL_W'(fix_q))
                                                  : $signed(LVL_W'(fix_q));
    assign mx_lvl  = $signed(LVL_W'(r_thrust_cap));
    assign abs_ml  = r_ml[LVL_W-1] ? -r_ml : r_ml;
    assign abs_mr  = r_mr[LVL_W-1] ? -r_mr : r_mr;

    assign n_prod = dtm_pkg::PROD_W'(mul_a) * dtm_pkg::PROD_W'(mul_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = is_mix ? dtm_pkg::S_SCALE : dtm_pkg::S_DONE;
                end
            end
            dtm_pkg::S_SCALE:    n_state = dtm_pkg::S_RECIP;
            dtm_pkg::S_RECIP:    n_state = dtm_pkg::S_CHECK;
            dtm_pkg::S_CHECK:    n_state = dtm_pkg::S_FIX;
            dtm_pkg::S_FIX:      n_state = r_side ? dtm_pkg::S_OVL : dtm_pkg::S_SCALE;
            dtm_pkg::S_OVL:      n_state = dtm_pkg::S_OVR;
            dtm_pkg::S_OVR:      n_state = dtm_pkg::S_CLAMP;
            dtm_pkg::S_CLAMP:    n_state = dtm_pkg::S_GAIN_L;
            dtm_pkg::S_GAIN_L:   n_state = dtm_pkg::S_GAIN_R;
            dtm_pkg::S_GAIN_R:   n_state = dtm_pkg::S_GAIN_END;
            dtm_pkg::S_GAIN_END: n_state = dtm_pkg::S_DONE;
            dtm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dtm_pkg::S_IDLE;
                end
            end
            default:             n_state = dtm_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_dir_l     = r_dir_l;
        n_dir_r     = r_dir_r;
        n_mag_l     = r_mag_l;
        n_mag_r     = r_mag_r;
        n_neg_l     = r_neg_l;
        n_neg_r     = r_neg_r;
        n_side      = r_side;
        n_x         = r_x;
        n_q         = r_q;
        n_ml        = r_ml;
        n_mr        = r_mr;
        n_lcmd      = r_lcmd;
        n_rcmd      = r_rcmd;
        n_direct    = r_direct;
        n_res_l     = r_res_l;
        n_res_r     = r_res_r;
        n_res_d     = r_res_d;
        n_out_valid = r_out_valid && !o_res.ready;
        mul_a       = '0;
        mul_b       = '0;
        unique case (r_state)
            dtm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_direct = !is_mix;
                    n_side   = 1'b0;
                    if (is_mix) begin
                        n_dir_l = '0;
                        n_dir_r = '0;
                        n_mag_l = abs_l[MAG_W-1:0];
                        n_mag_r = abs_r[MAG_W-1:0];
                        n_neg_l = mix_l[16];
                        n_neg_r = mix_r[16];
                    end else begin
                        n_dir_l = step_l;
                        n_dir_r = step_r;
                        n_lcmd  = step_l;
                        n_rcmd  = step_r;
                    end
                end
            end
            dtm_pkg::S_SCALE: begin
                mul_a = dtm_pkg::MUL_A_W'(r_side ? r_mag_r : r_mag_l);
                mul_b = dtm_pkg::MUL_B_W'(r_thrust_cap);
            end
            dtm_pkg::S_RECIP: begin
                n_x   = r_prod[X_W-1:0];
                mul_a = r_prod[X_W-1:0];
                mul_b = dtm_pkg::MUL_B_W'(dtm_pkg::RECIP);
            end
            dtm_pkg::S_CHECK: begin
                n_q   = r_prod[dtm_pkg::RECIP_SHIFT +: Q_W];
                mul_a = dtm_pkg::MUL_A_W'(r_prod[dtm_pkg::RECIP_SHIFT +: Q_W]);
                mul_b = dtm_pkg::MUL_B_W'(dtm_pkg::FULL_SCALE);
            end
            dtm_pkg::S_FIX: begin
                if (r_side) begin
                    n_mr = fix_lvl;
                end else begin
                    n_ml = fix_lvl;
                end
                n_side = 1'b1;
            end
            dtm_pkg::S_OVL: begin
                if (r_ml > mx_lvl) begin
                    n_mr = r_mr - r_ml + mx_lvl;
                end else if (r_ml < -mx_lvl) begin
                    n_mr = r_mr - r_ml - mx_lvl;
                end
            end
            dtm_pkg::S_OVR: begin
                if (r_mr > mx_lvl) begin
                    n_ml = r_ml - r_mr + mx_lvl;
                end else if (r_mr < -mx_lvl) begin
                    n_ml = r_ml - r_mr - mx_lvl;
                end
            end
            dtm_pkg::S_CLAMP: begin
                n_ml = clamp_lvl(r_ml, mx_lvl);
                n_mr = clamp_lvl(r_mr, mx_lvl);
            end
            dtm_pkg::S_GAIN_L: begin
                mul_a = dtm_pkg::MUL_A_W'(abs_ml[dtm_pkg::MAX_W-1:0]);
                mul_b = dtm_pkg::MUL_B_W'(r_left_gain);
            end
            dtm_pkg::S_GAIN_R: begin
                n_lcmd = gain_cmd(r_prod, r_ml[LVL_W-1]);
                mul_a  = dtm_pkg::MUL_A_W'(abs_mr[dtm_pkg::MAX_W-1:0]);
                mul_b  = dtm_pkg::MUL_B_W'(r_right_gain);
            end
            dtm_pkg::S_GAIN_END: begin
                n_rcmd = gain_cmd(r_prod, r_mr[LVL_W-1]);
            end
            dtm_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res_l     = r_lcmd;
                    n_res_r     = r_rcmd;
                    n_res_d     = r_direct;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_dir_l     <= '0;
            r_dir_r     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dir_l     <= n_dir_l;
            r_dir_r     <= n_dir_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_l  <= n_mag_l;
        r_mag_r  <= n_mag_r;
        r_neg_l  <= n_neg_l;
        r_neg_r  <= n_neg_r;
        r_side   <= n_side;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_q      <= n_q;
        r_ml     <= n_ml;
        r_mr     <= n_mr;
        r_lcmd   <= n_lcmd;
        r_rcmd   <= n_rcmd;
        r_direct <= n_direct;
        r_res_l  <= n_res_l;
        r_res_r  <= n_res_r;
        r_res_d  <= n_res_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thrust_cap <= '0;
            r_rudder_cap <= '0;
            r_left_gain  <= '0;
            r_right_gain <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (dtm_pkg::t_cfg_reg'(i_cfg.index))
                dtm_pkg::CFG_THRUST_CAP: r_thrust_cap <= i_cfg.data[dtm_pkg::MAX_W-1:0];
                dtm_pkg::CFG_RUDDER_CAP: r_rudder_cap <= i_cfg.data[dtm_pkg::MAX_W-1:0];
                dtm_pkg::CFG_LEFT_GAIN:  r_left_gain  <= i_cfg.data[dtm_pkg::GAIN_W-1:0];
                dtm_pkg::CFG_RIGHT_GAIN: r_right_gain <= i_cfg.data[dtm_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    a_recip_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtm_pkg::S_FIX) |-> (fix_rem < X_W'(2 * dtm_pkg::FULL_SCALE)))
        else $error("reciprocal estimate off by more than one");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir_l <= CMD_W'(dtm_pkg::DIRECT_LIMIT)) && (r_dir_l >= -CMD_W'(dtm_pkg::DIRECT_LIMIT))
        && (r_dir_r <= CMD_W'(dtm_pkg::DIRECT_LIMIT))
        && (r_dir_r >= -CMD_W'(dtm_pkg::DIRECT_LIMIT)))
        else $error("direct level out of range");

    a_mix_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_mix) |=> (r_dir_l == '0) && (r_dir_r == '0))
        else $error("direct levels not cleared by mixer item");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtm_pkg::S_GAIN_L) |->
        (r_ml <= mx_lvl) && (r_ml >= -mx_lvl) && (r_mr <= mx_lvl) && (r_mr >= -mx_lvl))
        else $error("mixed level exceeds thrust limit before gain");

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        (r_res_l <= CMD_W'(dtm_pkg::CMD_LIMIT)) && (r_res_l >= -CMD_W'(dtm_pkg::CMD_LIMIT))
        && (r_res_r <= CMD_W'(dtm_pkg::CMD_LIMIT))
        && (r_res_r >= -CMD_W'(dtm_pkg::CMD_LIMIT)))
        else $error("motor command out of range");

endmodule

`default_nettype wire
